FILE: hdl/bps_pkg.sv
// Beep pattern sequencer package: phase and command codes, item and result
// types, preset pattern table. No dependencies.
`default_nettype none

package bps_pkg;

  localparam int TIME_BITS_DEF = 16;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  localparam logic [7:0] ST_OK   = 8'd0;
  localparam logic [7:0] ST_IMU  = 8'd1;
  localparam logic [7:0] ST_SD   = 8'd2;
  localparam logic [7:0] ST_ALTI = 8'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  count;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] tone_freq;
    logic [7:0]  status_code;
  } item_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_hz;
    logic [1:0]  phase;
    logic [7:0]  beeps_left;
  } result_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  count;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] hz;
  } preset_t;

  function automatic preset_t preset_lookup(input logic [7:0] code);
    preset_t p;
    p = '0;
    case (code)
      ST_OK:   p = '{hit: 1'b1, count: 8'd3, on_ms: 16'd200, off_ms: 16'd100, hz: 16'd1500};
      ST_IMU:  p = '{hit: 1'b1, count: 8'd4, on_ms: 16'd600, off_ms: 16'd100, hz: 16'd500};
      ST_SD:   p = '{hit: 1'b1, count: 8'd3, on_ms: 16'd600, off_ms: 16'd100, hz: 16'd500};
      ST_ALTI: p = '{hit: 1'b1, count: 8'd2, on_ms: 16'd600, off_ms: 16'd100, hz: 16'd500};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bps_if.sv
// Valid/ready channel interfaces for the beep pattern sequencer.
// Depends on nothing; widths follow the item and result fields.
`default_nettype none

interface bps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  count;
  logic [15:0] on_ms;
  logic [15:0] off_ms;
  logic [15:0] tone_freq;
  logic [7:0]  status_code;

  modport source (output valid, func, count, on_ms, off_ms, tone_freq, status_code,
                  input ready);
  modport sink (input valid, func, count, on_ms, off_ms, tone_freq, status_code,
                output ready);
endinterface

interface bps_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_hz;
  logic [1:0]  phase;
  logic [7:0]  beeps_left;

  modport source (output valid, tone_on, tone_hz, phase, beeps_left, input ready);
  modport sink (input valid, tone_on, tone_hz, phase, beeps_left, output ready);
endinterface

`default_nettype wire

FILE: hdl/bps_in_reg.sv
// Input register stage: captures one item per transfer and holds it until
// the engine consumes it. Uses bps_pkg and bps_in_if.
`default_nettype none

module bps_in_reg (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bps_in_if.sink      in_ch,
  input  wire logic   adv,
  output bps_pkg::item_t item,
  output logic        item_valid
);
  import bps_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{func: in_ch.func, count: in_ch.count, on_ms: in_ch.on_ms,
                  off_ms: in_ch.off_ms, tone_freq: in_ch.tone_freq,
                  status_code: in_ch.status_code};
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

FILE: hdl/bps_engine.sv
// Pattern state and next-state logic: applies one item per step and gives
// the result of the new state. Uses bps_pkg.
`default_nettype none

module bps_engine #(
  parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire bps_pkg::item_t item,
  output bps_pkg::result_t    res
);
  import bps_pkg::*;

  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [7:0]           remaining_r, remaining_nxt;
  logic [15:0]          on_len_r, on_len_nxt;
  logic [15:0]          off_len_r, off_len_nxt;
  logic [15:0]          freq_r, freq_nxt;
  logic [CW-1:0]        el_ext;
  logic                 on_done, off_done;
  preset_t              pre;
  preset_t              load;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign el_ext      = CW'(elapsed_inc);
  assign on_done     = el_ext >= CW'(on_len_r);
  assign off_done    = el_ext >= CW'(off_len_r);
  assign pre         = preset_lookup(item.status_code);

  always_comb begin
    load = '0;
    case (item.func)
      FUNC_START: begin
        load = '{hit: (item.count != 8'd0), count: item.count, on_ms: item.on_ms,
                 off_ms: item.off_ms, hz: item.tone_freq};
      end
      FUNC_STATUS: load = pre;
      default:     load = '0;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    remaining_nxt = remaining_r;
    on_len_nxt    = on_len_r;
    off_len_nxt   = off_len_r;
    freq_nxt      = freq_r;
    if (load.hit) begin
      phase_nxt     = PH_ON;
      elapsed_nxt   = '0;
      remaining_nxt = load.count;
      on_len_nxt    = load.on_ms;
      off_len_nxt   = load.off_ms;
      freq_nxt      = load.hz;
    end else if (item.func == FUNC_TICK) begin
      case (phase_r)
        PH_ON: begin
          elapsed_nxt = elapsed_inc;
          if (on_done) begin
            elapsed_nxt = '0;
            phase_nxt   = PH_OFF;
          end
        end
        PH_OFF: begin
          elapsed_nxt = elapsed_inc;
          if (off_done) begin
            if (remaining_r > 8'd1) begin
              remaining_nxt = remaining_r - 8'd1;
              elapsed_nxt   = '0;
              phase_nxt     = PH_ON;
            end else begin
              remaining_nxt = 8'd0;
              phase_nxt     = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      remaining_r <= '0;
      on_len_r    <= '0;
      off_len_r   <= '0;
      freq_r      <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      remaining_r <= remaining_nxt;
      on_len_r    <= on_len_nxt;
      off_len_r   <= off_len_nxt;
      freq_r      <= freq_nxt;
    end
  end

  always_comb begin
    res.tone_on    = (phase_nxt == PH_ON);
    res.tone_hz    = freq_nxt;
    res.beeps_left = remaining_nxt;
    case (phase_nxt)
      PH_ON:   res.phase = PH_ON;
      PH_OFF:  res.phase = PH_OFF;
      default: res.phase = PH_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/beep_pattern_sequencer_top.sv
// Beep pattern sequencer top level: input register, pattern engine and
// result register. Uses bps_pkg, bps_if, bps_in_reg and bps_engine.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        func, count, on_ms, off_ms, tone_freq, status_code
//   out_ch   out  valid/ready        tone_on, tone_hz, phase, beeps_left
//
// One item per cycle sustained while out_ch.ready is high; an item's result passes
// the input register, then the result register, before it is offered on out_ch.
// rst_n is synchronous, active low; it clears the pattern state to idle.
// A stalled result register holds; the input register still takes one more
// item, then in_ch.ready drops until the result is taken.
`default_nettype none

module beep_pattern_sequencer_top #(
  parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bps_in_if.sink    in_ch,
  bps_out_if.source out_ch
);
  import bps_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    adv;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;

  assign adv = item_valid && (!out_valid_r || out_ch.ready);

  bps_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .item       (item),
    .item_valid (item_valid)
  );

  bps_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tone_on    = res_r.tone_on;
  assign out_ch.tone_hz    = res_r.tone_hz;
  assign out_ch.phase      = res_r.phase;
  assign out_ch.beeps_left = res_r.beeps_left;

`ifndef SYNTHESIS
  a_idle_no_beeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.phase == PH_IDLE) |-> (res_r.beeps_left == 8'd0))
    else $error("idle result reports beeps left");

  a_active_has_beeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.phase != PH_IDLE) |-> (res_r.beeps_left != 8'd0))
    else $error("active pattern with no beeps left");

  a_tone_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.tone_on == (res_r.phase == PH_ON)))
    else $error("tone enable disagrees with phase");

  a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> in_ch.ready)
    else $error("input stage empty but not ready");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("engine step lost its result");
`endif

endmodule

`default_nettype wire
